[sv/spwm_pkg.sv]
package spwm_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int COUNTER_BITS_DEF = 24;

    // Fixed field widths.
    localparam int MODE_W    = 2;
    localparam int CHAN_W    = 2;
    localparam int ANGLE_W   = 16;
    localparam int TICK_W    = 24;
    localparam int CHEN_W    = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 24;

    // Reset values.
    localparam logic [TICK_W-1:0] PERIOD_RESET  = 24'd320000;
    localparam logic [TICK_W-1:0] COMPARE_RESET = 24'd8000;

    // Angle scaling: ticks = min(angle, 270) * 32000 / 270 + 8000.
    // The division by 270 is folded into a reciprocal: 32000/270 = 3200/27,
    // and floor(x/27) = (x * ceil(2^25/27)) >> 25 for every x up to 864000.
    localparam int ANGLE_SAT_W = 9;
    localparam logic [ANGLE_SAT_W-1:0] ANGLE_MAX = 9'd270;
    localparam int SCALE_MUL_W = 32;
    localparam logic [SCALE_MUL_W-1:0] ANGLE_SCALE_MUL = 32'd3976822400;
    localparam int ANGLE_SCALE_SHIFT = 25;
    localparam int ANGLE_PROD_W = ANGLE_SAT_W + SCALE_MUL_W;
    localparam logic [TICK_W-1:0] ANGLE_OFFSET = 24'd8000;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_ANGLE = 2'd1,
        MODE_RAW   = 2'd2
    } mode_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD  = 4'd0,
        CFG_RUN     = 4'd1,
        CFG_CHAN_EN = 4'd2
    } cfg_reg_e;

    typedef struct packed {
        logic [TICK_W-1:0] period;
        logic              run;
        logic [CHEN_W-1:0] chan_en;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAN_W-1:0] channel;
        logic [TICK_W-1:0] angle_ticks;
        logic [TICK_W-1:0] raw_ticks;
    } cmd_t;

endpackage

[sv/spwm_angle_scale.sv]
module spwm_angle_scale
    import spwm_pkg::*;
(
    input  logic [ANGLE_W-1:0] angle_deg,
    output logic [TICK_W-1:0]  angle_ticks
);

    logic [ANGLE_SAT_W-1:0]  angle_sat;
    logic [ANGLE_PROD_W-1:0] prod;
    logic [TICK_W-1:0]       quot;

    // Saturate to the mechanical range, then scale through the reciprocal.
    assign angle_sat   = (angle_deg > ANGLE_W'(ANGLE_MAX)) ? ANGLE_MAX
                                                           : angle_deg[ANGLE_SAT_W-1:0];
    assign prod        = ANGLE_PROD_W'(angle_sat) * ANGLE_PROD_W'(ANGLE_SCALE_MUL);
    assign quot        = TICK_W'(prod >> ANGLE_SCALE_SHIFT);
    assign angle_ticks = quot + ANGLE_OFFSET;

endmodule

[sv/spwm_core.sv]
module spwm_core
    import spwm_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  cmd_t                    cmd,
    input  cfg_t                    cfg,
    output logic [NUM_CHANNELS-1:0] levels_next,
    output logic                    wrap_next
);

    localparam int CMP_W = (COUNTER_BITS > TICK_W) ? COUNTER_BITS : TICK_W;

    logic [COUNTER_BITS-1:0] tick_count_reg;
    logic [COUNTER_BITS-1:0] tick_count_next;
    logic [COUNTER_BITS-1:0] count_inc;
    logic [NUM_CHANNELS-1:0] levels_reg;
    logic [NUM_CHANNELS-1:0] ch_en;
    logic [NUM_CHANNELS-1:0] hit;
    logic [TICK_W-1:0]       cmp_reg [NUM_CHANNELS];
    logic [TICK_W-1:0]       clamp_hi;
    logic [TICK_W-1:0]       wr_src;
    logic [TICK_W-1:0]       wr_value;
    logic                    is_tick;
    logic                    is_write;
    logic                    wrap_hit;

    assign is_tick  = fire && (cmd.mode == MODE_TICK) && cfg.run;
    assign is_write = fire && ((cmd.mode == MODE_ANGLE) || (cmd.mode == MODE_RAW));

    assign count_inc = tick_count_reg + 1'b1;
    assign wrap_hit  = (count_inc == '0) || (CMP_W'(count_inc) >= CMP_W'(cfg.period));

    // A written pulse width is kept inside the frame: 1 .. period-1.
    assign clamp_hi = (cfg.period >= 24'd2) ? (cfg.period - 24'd1) : 24'd1;
    assign wr_src   = (cmd.mode == MODE_ANGLE) ? cmd.angle_ticks : cmd.raw_ticks;
    assign wr_value = (wr_src == '0)       ? 24'd1 :
                      (wr_src > clamp_hi)  ? clamp_hi : wr_src;

    genvar n;
    generate
        for (n = 0; n < NUM_CHANNELS; n++) begin : g_ch
            if (n < CHEN_W) begin : g_en
                assign ch_en[n] = cfg.chan_en[n];
            end else begin : g_no_en
                assign ch_en[n] = 1'b0;
            end

            assign hit[n] = ch_en[n] && (CMP_W'(count_inc) == CMP_W'(cmp_reg[n]));

            always_ff @(posedge clk or negedge rst_n) begin
                if (!rst_n) begin
                    cmp_reg[n] <= COMPARE_RESET;
                end else if (is_write && (32'(cmd.channel) == n)) begin
                    cmp_reg[n] <= wr_value;
                end
            end
        end
    endgenerate

    always_comb begin
        tick_count_next = tick_count_reg;
        levels_next     = levels_reg;
        if (is_tick) begin
            if (wrap_hit) begin
                tick_count_next = '0;
                levels_next     = levels_reg | ch_en;
            end else begin
                tick_count_next = count_inc;
                levels_next     = levels_reg & ~hit;
            end
        end
    end

    assign wrap_next = is_tick && wrap_hit;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tick_count_reg <= '0;
            levels_reg     <= '1;
        end else begin
            tick_count_reg <= tick_count_next;
            levels_reg     <= levels_next;
        end
    end

endmodule

[sv/servo_pwm_generator_4ch.sv]
// Four-channel servo PWM generator.
//
// Input channel (in_valid / in_stall) carries one word per command: a tick
// of the PWM time base, a pulse width given as an angle in degrees, or a
// pulse width given as raw ticks. Every accepted word yields exactly one
// result word on the output channel (out_valid / out_stall) holding the
// current level of each channel and a flag that marks the tick that wrapped
// the counter and started a new frame.
// The configuration channel (cfg_valid / cfg_ready) writes the frame length,
// the run enable and the per-channel enables; cfg_ready is always high and
// registers should only be written while no words are in flight.
// A word accepted sits in the input register until the result register is free;
// then its result is loaded into the result register and out_valid rises.
// Throughput is one word per cycle while out_stall is low; the input register
// and the result register decouple the two sides, so a word is taken while a
// result waits. When the receiver stalls, the result holds and the input
// register fills; in_stall rises only when that register is full and the
// result is stalled. Reset clears the counter, sets every compare value to
// 8000 ticks, sets the core's channel levels high, clears out_valid and
// restores the default frame length of 320000 ticks with everything disabled.
module servo_pwm_generator_4ch
    import spwm_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [MODE_W-1:0]       mode,
    input  logic [CHAN_W-1:0]       channel,
    input  logic [ANGLE_W-1:0]      angle_deg,
    input  logic [TICK_W-1:0]       raw_ticks,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [NUM_CHANNELS-1:0] pwm_levels,
    output logic                    frame_wrap,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DAT_W-1:0]    cfg_data
);

    // Configuration registers.
    logic [TICK_W-1:0] period_reg;
    logic              run_reg;
    logic [CHEN_W-1:0] chan_en_reg;
    cfg_t              cfg;

    // Input register stage.
    logic               s1_valid_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [CHAN_W-1:0]  channel_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic [TICK_W-1:0]  raw_reg;

    // Result register stage.
    logic                    out_valid_reg;
    logic [NUM_CHANNELS-1:0] pwm_levels_reg;
    logic                    frame_wrap_reg;

    logic                    in_take;
    logic                    out_free;
    logic                    fire;
    logic [TICK_W-1:0]       angle_ticks;
    cmd_t                    cmd;
    logic [NUM_CHANNELS-1:0] levels_next;
    logic                    wrap_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            period_reg  <= PERIOD_RESET;
            run_reg     <= 1'b0;
            chan_en_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_PERIOD:  period_reg  <= cfg_data[TICK_W-1:0];
                CFG_RUN:     run_reg     <= cfg_data[0];
                CFG_CHAN_EN: chan_en_reg <= cfg_data[CHEN_W-1:0];
                default:     ;
            endcase
        end
    end

    assign cfg.period  = period_reg;
    assign cfg.run     = run_reg;
    assign cfg.chan_en = chan_en_reg;

    // The result register is free when empty or being taken this cycle; the
    // input stage moves forward whenever that is so.
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_take) begin
                s1_valid_reg <= 1'b1;
            end else if (fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_take) begin
            mode_reg    <= mode;
            channel_reg <= channel;
            angle_reg   <= angle_deg;
            raw_reg     <= raw_ticks;
        end
        if (fire) begin
            pwm_levels_reg <= levels_next;
            frame_wrap_reg <= wrap_next;
        end
    end

    spwm_angle_scale u_angle_scale (
        .angle_deg   (angle_reg),
        .angle_ticks (angle_ticks)
    );

    assign cmd.mode        = mode_reg;
    assign cmd.channel     = channel_reg;
    assign cmd.angle_ticks = angle_ticks;
    assign cmd.raw_ticks   = raw_reg;

    spwm_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .cmd         (cmd),
        .cfg         (cfg),
        .levels_next (levels_next),
        .wrap_next   (wrap_next)
    );

    assign out_valid  = out_valid_reg;
    assign pwm_levels = pwm_levels_reg;
    assign frame_wrap = frame_wrap_reg;

endmodule

[sv/spwm_checker.sv]
module spwm_checker
    import spwm_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_stall,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [NUM_CHANNELS-1:0] pwm_levels,
    input  logic                    frame_wrap
);

    logic                    out_take;
    logic                    seen_reg;
    logic [NUM_CHANNELS-1:0] last_levels_reg;

    assign out_take = out_valid && !out_stall;

    // Level seen on the previous delivered word.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seen_reg        <= 1'b0;
            last_levels_reg <= '1;
        end else if (out_take) begin
            seen_reg        <= 1'b1;
            last_levels_reg <= pwm_levels;
        end
    end

    // A stalled result word stays and holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pwm_levels) && $stable(frame_wrap))
        else $error("result word changed while stalled");

    // The input side only backs up when a result is waiting on a stalled receiver.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // An output can only go high at the start of a frame.
    a_rise_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && seen_reg && !frame_wrap |-> (pwm_levels & ~last_levels_reg) == '0)
        else $error("output level rose without a frame wrap");

endmodule

bind servo_pwm_generator_4ch spwm_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_spwm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pwm_levels (pwm_levels),
    .frame_wrap (frame_wrap)
);
